>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the encoder RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/u16u8_pkg.sv
// ---------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 length and byte functions of the encoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

   localparam int JOB_DEPTH = 4;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [20:0] REPL_CP    = 21'h00FFFD;
   localparam logic [20:0] ONE_LIMIT  = 21'h80;
   localparam logic [20:0] TWO_LIMIT  = 21'h800;
   localparam logic [20:0] THREE_LIMIT = 21'h10000;

   // length minus one of a UTF-8 sequence
   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   // Work handed from front to back: optional U+FFFD, then optional code point.
   typedef struct packed {
      logic        rep;
      logic        has_cp;
      logic [20:0] cp;
      logic [1:0]  lm1;
   } job_type;

   function automatic logic [1:0] utf8_lm1(input logic [20:0] cp);
      logic [1:0] lm1;
      if (cp < ONE_LIMIT) lm1 = LEN_ONE;
      else if (cp < TWO_LIMIT) lm1 = LEN_TWO;
      else if (cp < THREE_LIMIT) lm1 = LEN_THREE;
      else lm1 = LEN_FOUR;
      return lm1;
   endfunction

   // Byte number idx of the UTF-8 sequence of cp, sequence length lm1 + 1.
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [1:0]  lm1,
                                            input logic [1:0]  idx);
      logic [7:0] b;
      logic [1:0] pos;
      pos = lm1 - idx;
      if (idx == 2'd0) begin
         case (lm1)
            LEN_ONE:   b = cp[7:0];
            LEN_TWO:   b = {3'b110, cp[10:6]};
            LEN_THREE: b = {4'b1110, cp[15:12]};
            LEN_FOUR:  b = {5'b11110, cp[20:18]};
            default:   b = cp[7:0];
         endcase
      end else begin
         case (pos)
            2'd0:    b = {2'b10, cp[5:0]};
            2'd1:    b = {2'b10, cp[11:6]};
            2'd2:    b = {2'b10, cp[17:12]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end
      return b;
   endfunction

endpackage

>>> sv/u16u8_front.sv
// ---------------------------------------------------------------------------
// u16u8_front
// Classifies code units, tracks a pending high surrogate and builds jobs.
// ---------------------------------------------------------------------------
module u16u8_front
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] code_unit,
   input  logic        final_unit,
   output logic        job_push,
   output job_type     job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       is_high, is_low, hold_new;

   assign is_high  = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
   assign is_low   = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
   assign hold_new = is_high && !final_unit;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      job.rep       = 1'b0;
      job.has_cp    = 1'b0;
      job.cp        = {5'd0, code_unit};
      if (held_valid_ff && is_low) begin
         job.cp     = {1'b0, held_bits_ff, code_unit[9:0]} + SUPP_BASE;
         job.has_cp = 1'b1;
      end else begin
         job.rep    = held_valid_ff;
         job.has_cp = !hold_new;
      end
      job.lm1 = utf8_lm1(job.cp);
      if (accept) begin
         held_valid_in = !(held_valid_ff && is_low) && hold_new;
         held_bits_in  = code_unit[9:0];
      end
   end

   assign job_push = accept && (job.rep || job.has_cp);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
      held_bits_ff <= held_bits_in;
   end

endmodule

>>> sv/u16u8_fifo.sv
// ---------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between front and back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_fifo
   import u16u8_pkg::*;
#(
   parameter int Depth = JOB_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   job_type         slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slots_ff[wr_ptr_ff] <= push_job;
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && full, "job pushed into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "job popped from empty queue")

endmodule

>>> sv/u16u8_back.sv
// ---------------------------------------------------------------------------
// u16u8_back
// Emits the UTF-8 bytes of each job, one byte per cycle while the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_back
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job,
   output logic       job_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   job_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic       in_rep_ff, in_rep_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       run_last_ff, run_last_in;

   logic       out_free, emit, phase_last, job_done;
   logic [1:0] phase_lm1;
   logic [7:0] next_byte;

   assign out_free   = !out_valid_ff || rsp_pop;
   assign emit       = cur_valid_ff && out_free;
   assign phase_lm1  = in_rep_ff ? LEN_THREE : cur_ff.lm1;
   assign phase_last = (idx_ff == phase_lm1);
   assign job_done   = phase_last && !(in_rep_ff && cur_ff.has_cp);
   assign next_byte  = in_rep_ff ? utf8_byte(REPL_CP, LEN_THREE, idx_ff)
                                 : utf8_byte(cur_ff.cp, cur_ff.lm1, idx_ff);
   assign job_pop    = !job_empty && (!cur_valid_ff || (emit && job_done));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      in_rep_in    = in_rep_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = next_byte;
         run_last_in  = job_done;
         if (job_done) begin
            cur_valid_in = 1'b0;
         end else if (phase_last) begin
            // replacement done, move on to the new unit
            in_rep_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (job_pop) begin
         cur_in       = job;
         cur_valid_in = 1'b1;
         in_rep_in    = job.rep;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      in_rep_ff   <= in_rep_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;

   `ASSERT_CLK(a_idx_range, clock, reset, cur_valid_ff && !in_rep_ff |-> idx_ff <= cur_ff.lm1, "byte index past sequence end")
   `ASSERT_CLK(a_rep_job, clock, reset, cur_valid_ff && in_rep_ff |-> cur_ff.rep && idx_ff <= LEN_THREE, "replacement phase without replacement job")

endmodule

>>> sv/utf16_to_utf8_encoder.sv
// First UTF-8 byte of a code unit passes the job queue, current-job and output registers.
// Throughput: one byte per cycle from the back end's single byte lane while the result
//   register is free; an item yields 0 to 6 bytes (2 or 3 for non-ASCII BMP text).
// Input side runs ahead of output by up to Depth queued jobs plus the job in flight.
// Reset (synchronous, active high) drops any held high surrogate, queued jobs and results.
// ---------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and U+FFFD.
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder
   import u16u8_pkg::*;
#(
   parameter int Depth = JOB_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_code_unit,
   input  logic        req_final_unit,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last
);

   job_type front_job, back_job;
   logic    accept, job_push, job_pop, job_empty;

   assign accept = push && !full;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .code_unit  (req_code_unit),
      .final_unit (req_final_unit),
      .job_push   (job_push),
      .job        (front_job)
   );

   u16u8_fifo #(.Depth(Depth)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (full),
      .pop      (job_pop),
      .pop_job  (back_job),
      .empty    (job_empty)
   );

   u16u8_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_empty    (job_empty),
      .job          (back_job),
      .job_pop      (job_pop),
      .rsp_pop      (pop),
      .rsp_empty    (empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule
